### design/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg
// Types and constants shared by the token splitter modules.
// ----------------------------------------------------------------------------
package tst_pkg;

  // Result kinds
  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_UNTERM  = 2'd2;

  // Scan modes (any other code acts as text)
  localparam logic [1:0] MODE_TEXT    = 2'd0;
  localparam logic [1:0] MODE_BLOCK   = 2'd1;
  localparam logic [1:0] MODE_LINE    = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;

  localparam logic [7:0]  EXTRA_DELIM_RESET = 8'd37;
  localparam logic [15:0] LINE_MAX          = 16'hFFFF;

  // Results one item can cause, and default depth of the item queue
  localparam int MAX_RESULTS   = 4;
  localparam int QUEUE_DEPTH   = 4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       extra_delim_on;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  token_byte;
    logic [15:0] line_number;
    logic        last_of_run;
  } out_item_t;

  // One result before it is tagged as last of its run
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  token_byte;
    logic [15:0] line_number;
  } res_t;

  // All results of one input item
  typedef struct packed {
    logic [2:0]                  cnt;
    res_t [MAX_RESULTS-1:0]      res;
  } bundle_t;

  // One-character token bytes
  function automatic logic is_single(input logic [7:0] c);
    case (c)
      8'h7B, 8'h7D, 8'h3D, 8'h3A, 8'h2C, 8'h3C, 8'h3E, 8'h22,
      8'h2E, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h27, CH_SEMI: is_single = 1'b1;
      default: is_single = 1'b0;
    endcase
  endfunction

  // Saturating line increment
  function automatic logic [15:0] bump(input logic [15:0] l);
    bump = (l == LINE_MAX) ? l : l + 16'd1;
  endfunction

endpackage

### design/tst_front.sv
// ----------------------------------------------------------------------------
// tst_front
// Accepts one byte per cycle while the queue has room, tracks scan state
// and builds the bundle of results that the byte causes.
// ----------------------------------------------------------------------------
module tst_front
  import tst_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic [7:0] cfg_data,
  input  logic     push,
  input  logic     q_full,
  input  in_item_t in_data,
  output logic     q_wr,
  output bundle_t  q_wdata
);

  logic [7:0]  extra_delim_char;
  logic        token_open, held_valid, held_delim, comment_prev_star;
  logic [7:0]  held_byte;
  logic [1:0]  scan_mode;
  logic [15:0] line_count;

  logic        token_open_next, held_valid_next, held_delim_next, comment_prev_star_next;
  logic [7:0]  held_byte_next;
  logic [1:0]  scan_mode_next;
  logic [15:0] line_count_next;
  bundle_t     bnd;
  logic        accept, is_extra;
  logic [7:0]  c;

  assign accept = push && !q_full;
  assign c      = in_data.text_byte;
  assign is_extra = in_data.extra_delim_on && (c == extra_delim_char);

  // Step of the scanner for one byte
  always_comb begin
    token_open_next        = token_open;
    held_valid_next        = held_valid;
    held_delim_next        = held_delim;
    held_byte_next         = held_byte;
    scan_mode_next         = scan_mode;
    comment_prev_star_next = comment_prev_star;
    line_count_next        = line_count;
    bnd                    = '0;

    if (scan_mode == MODE_BLOCK) begin
      if (c == CH_LF) line_count_next = bump(line_count_next);
      if (c == CH_SLASH && comment_prev_star) begin
        scan_mode_next         = MODE_TEXT;
        comment_prev_star_next = 1'b0;
      end else begin
        comment_prev_star_next = (c == CH_STAR);
      end
    end else if (scan_mode == MODE_LINE) begin
      if (c == CH_LF || c == CH_CR) begin
        line_count_next = bump(line_count_next);
        scan_mode_next  = MODE_TEXT;
      end
    end else if (held_valid && held_byte == CH_SLASH && c == CH_STAR) begin
      if (token_open_next) begin
        bnd.res[bnd.cnt[1:0]] = '{KIND_END, 8'd0, line_count_next};
        bnd.cnt = bnd.cnt + 3'd1;
        token_open_next = 1'b0;
      end
      held_valid_next        = 1'b0;
      held_delim_next        = 1'b0;
      scan_mode_next         = MODE_BLOCK;
      comment_prev_star_next = 1'b1;
    end else if (held_valid && held_byte == CH_DASH && c == CH_DASH) begin
      if (token_open_next) begin
        bnd.res[bnd.cnt[1:0]] = '{KIND_END, 8'd0, line_count_next};
        bnd.cnt = bnd.cnt + 3'd1;
        token_open_next = 1'b0;
      end
      held_valid_next = 1'b0;
      held_delim_next = 1'b0;
      scan_mode_next  = MODE_LINE;
    end else begin
      // release the held byte
      if (held_valid_next) begin
        bnd.res[bnd.cnt[1:0]] = '{KIND_CHAR, held_byte_next, line_count_next};
        bnd.cnt = bnd.cnt + 3'd1;
        if (held_delim_next) begin
          bnd.res[bnd.cnt[1:0]] = '{KIND_END, 8'd0, line_count_next};
          bnd.cnt = bnd.cnt + 3'd1;
        end else begin
          token_open_next = 1'b1;
        end
        held_valid_next = 1'b0;
        held_delim_next = 1'b0;
      end
      // classify the new byte
      if (c == CH_SLASH || c == CH_DASH) begin
        held_byte_next  = c;
        held_valid_next = 1'b1;
        held_delim_next = is_extra;
        if (is_extra && token_open_next) begin
          bnd.res[bnd.cnt[1:0]] = '{KIND_END, 8'd0, line_count_next};
          bnd.cnt = bnd.cnt + 3'd1;
          token_open_next = 1'b0;
        end
      end else if (c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_TAB) begin
        if (token_open_next) begin
          bnd.res[bnd.cnt[1:0]] = '{KIND_END, 8'd0, line_count_next};
          bnd.cnt = bnd.cnt + 3'd1;
          token_open_next = 1'b0;
        end
        if (c == CH_LF) line_count_next = bump(line_count_next);
      end else if (is_single(c) || is_extra) begin
        if (token_open_next && bnd.cnt != 3'd4) begin
          bnd.res[bnd.cnt[1:0]] = '{KIND_END, 8'd0, line_count_next};
          bnd.cnt = bnd.cnt + 3'd1;
        end
        token_open_next = 1'b0;
        if (bnd.cnt != 3'd4) begin
          bnd.res[bnd.cnt[1:0]] = '{KIND_CHAR, c, line_count_next};
          bnd.cnt = bnd.cnt + 3'd1;
        end
        if (bnd.cnt != 3'd4) begin
          bnd.res[bnd.cnt[1:0]] = '{KIND_END, 8'd0, line_count_next};
          bnd.cnt = bnd.cnt + 3'd1;
        end
      end else begin
        if (bnd.cnt != 3'd4) begin
          bnd.res[bnd.cnt[1:0]] = '{KIND_CHAR, c, line_count_next};
          bnd.cnt = bnd.cnt + 3'd1;
        end
        token_open_next = 1'b1;
      end
    end

    // end of text: flush held byte, close token, flag open block comment
    if (in_data.end_of_text) begin
      if (held_valid_next) begin
        if (bnd.cnt != 3'd4) begin
          bnd.res[bnd.cnt[1:0]] = '{KIND_CHAR, held_byte_next, line_count_next};
          bnd.cnt = bnd.cnt + 3'd1;
        end
        if (held_delim_next) begin
          if (bnd.cnt != 3'd4) begin
            bnd.res[bnd.cnt[1:0]] = '{KIND_END, 8'd0, line_count_next};
            bnd.cnt = bnd.cnt + 3'd1;
          end
        end else begin
          token_open_next = 1'b1;
        end
      end
      if (token_open_next && bnd.cnt != 3'd4) begin
        bnd.res[bnd.cnt[1:0]] = '{KIND_END, 8'd0, line_count_next};
        bnd.cnt = bnd.cnt + 3'd1;
      end
      if (scan_mode_next == MODE_BLOCK && bnd.cnt != 3'd4) begin
        bnd.res[bnd.cnt[1:0]] = '{KIND_UNTERM, 8'd0, line_count_next};
        bnd.cnt = bnd.cnt + 3'd1;
      end
      token_open_next        = 1'b0;
      held_byte_next         = 8'd0;
      held_valid_next        = 1'b0;
      held_delim_next        = 1'b0;
      scan_mode_next         = MODE_TEXT;
      comment_prev_star_next = 1'b0;
      line_count_next        = 16'd0;
    end
  end

  assign q_wr    = accept && (bnd.cnt != 3'd0);
  assign q_wdata = bnd;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      extra_delim_char <= EXTRA_DELIM_RESET;
    end else if (cfg_we) begin
      extra_delim_char <= cfg_data;
    end
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      token_open        <= 1'b0;
      held_byte         <= 8'd0;
      held_valid        <= 1'b0;
      held_delim        <= 1'b0;
      scan_mode         <= MODE_TEXT;
      comment_prev_star <= 1'b0;
      line_count        <= 16'd0;
    end else if (accept) begin
      token_open        <= token_open_next;
      held_byte         <= held_byte_next;
      held_valid        <= held_valid_next;
      held_delim        <= held_delim_next;
      scan_mode         <= scan_mode_next;
      comment_prev_star <= comment_prev_star_next;
      line_count        <= line_count_next;
    end
  end

endmodule

### design/tst_queue.sv
// ----------------------------------------------------------------------------
// tst_queue
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module tst_queue
  import tst_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  bundle_t wdata,
  input  logic    rd,
  output bundle_t rdata,
  output logic    full,
  output logic    empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bundle_t        slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr, do_rd;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wdata;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

endmodule

### design/tst_back.sv
// ----------------------------------------------------------------------------
// tst_back
// Hands out the results of the head bundle one at a time.
// ----------------------------------------------------------------------------
module tst_back
  import tst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  bundle_t   head,
  input  logic      q_empty,
  input  logic      pop,
  output logic      q_rd,
  output out_item_t out_data
);

  logic [1:0] sub;
  logic       last;
  res_t       cur;

  assign cur  = head.res[sub];
  assign last = ({1'b0, sub} + 3'd1 == head.cnt);
  assign q_rd = pop && !q_empty && last;

  assign out_data.kind        = cur.kind;
  assign out_data.token_byte  = cur.token_byte;
  assign out_data.line_number = cur.line_number;
  assign out_data.last_of_run = last;

  // Index of the result within the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 2'd0;
    end else if (pop && !q_empty) begin
      sub <= last ? 2'd0 : sub + 2'd1;
    end
  end

endmodule

### design/sql_style_token_splitter_core.sv
// ----------------------------------------------------------------------------
// sql_style_token_splitter_core
// Splits a byte stream into tokens, skipping block and line comments.
//
//   channel   direction  handshake            payload
//   input     in         push / full          in_data  (in_item_t)
//   result    out        pop / empty          out_data (out_item_t)
//   config    in         cfg_we               cfg_data (extra delimiter)
//
// One byte is accepted per cycle while the queue has room; its results are
// queued and shown in order. The back drains one result per cycle while pop
// is high, so an item causing k results occupies the result port for k pops.
// Bytes that cause no result use no queue slot.
// Synchronous reset clears scan state and empties the queue; the delimiter
// register returns to '%'. A stalled result side fills the queue, then full.
// ----------------------------------------------------------------------------
module sql_style_token_splitter_core
  import tst_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [7:0] cfg_data,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  logic    q_wr, q_rd;
  bundle_t q_wdata, q_rdata;

  tst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .q_full   (full),
    .in_data  (in_data),
    .q_wr     (q_wr),
    .q_wdata  (q_wdata)
  );

  tst_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (full),
    .empty (empty)
  );

  tst_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_rdata),
    .q_empty  (empty),
    .pop      (pop),
    .q_rd     (q_rd),
    .out_data (out_data)
  );

endmodule

### design/tst_checker.sv
// ----------------------------------------------------------------------------
// tst_checker
// Port-level checks for the token splitter, bound to the top level.
// ----------------------------------------------------------------------------
module tst_checker
  import tst_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data
);

  // Reset leaves no results waiting
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("results present after reset");

  // No result kind beyond unterminated comment
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_data.kind == KIND_CHAR || out_data.kind == KIND_END ||
                out_data.kind == KIND_UNTERM))
    else $error("illegal result kind");

  // Only token characters carry a byte
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_data.kind != KIND_CHAR) |-> out_data.token_byte == 8'd0)
    else $error("byte on non-character result");

  // A run continues without a gap and its line count never drops
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !out_data.last_of_run) |=>
      (!empty && out_data.line_number >= $past(out_data.line_number)))
    else $error("run broken or line count fell");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind sql_style_token_splitter_core tst_checker u_tst_checker (
  .clk      (clk),
  .rst      (rst),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

### tb/tb_sql_style_token_splitter_core.sv
// ----------------------------------------------------------------------------
// tb_sql_style_token_splitter_core
// Self-checking bench for the token splitter. A fixed script of bytes walks
// the comment openers, delimiters, line counting and the end-of-text flush,
// then random phrases run under several extra-delimiter settings. Each result
// is compared field by field against a typed script row or the bench's predictor.
// ----------------------------------------------------------------------------
module tb_sql_style_token_splitter_core;
  import tst_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SCRIPT_LEN  = 27;
  localparam out_item_t NO_RES = '0;

  typedef struct packed {
    logic [7:0] c;
    logic       on;
    logic       eot;
    logic       typed;
    out_item_t  want;
  } script_row_t;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic [7:0] cfg_data;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;

  // Predictor state
  logic [7:0]  delim_char;
  logic        tok_open;
  logic [7:0]  hold_byte;
  logic        hold_on;
  logic        hold_is_delim;
  logic [1:0]  mode;
  logic        prev_star;
  logic [15:0] lines;

  out_item_t run_q[$];    // results of the byte being split
  out_item_t token_q[$];  // token results still to arrive

  int  err_cnt = 0;
  int  bytes_sent = 0;
  int  tokens_seen = 0;
  int  cycle_cnt = 0;
  bit  jitter = 1'b1;

  // Fixed script: typed results only after reset, at byte extremes, for the first
  // line break and for the unterminated comment; the rest goes through the predictor.
  script_row_t script [0:SCRIPT_LEN-1] = '{
    '{"a",    1'b0, 1'b0, 1'b1, '{KIND_CHAR, 8'h61, 16'd0, 1'b1}},
    '{8'h00,  1'b0, 1'b0, 1'b1, '{KIND_CHAR, 8'h00, 16'd0, 1'b1}},
    '{8'hFF,  1'b0, 1'b0, 1'b1, '{KIND_CHAR, 8'hFF, 16'd0, 1'b1}},
    '{CH_LF,  1'b0, 1'b0, 1'b1, '{KIND_END,  8'h00, 16'd0, 1'b1}},
    '{"%",    1'b1, 1'b0, 1'b0, NO_RES},
    '{"%",    1'b0, 1'b0, 1'b0, NO_RES},
    '{";",    1'b0, 1'b0, 1'b0, NO_RES},
    '{"b",    1'b0, 1'b0, 1'b0, NO_RES},
    '{"/",    1'b0, 1'b0, 1'b0, NO_RES},
    '{"*",    1'b0, 1'b0, 1'b0, NO_RES},
    '{"/",    1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_LF,  1'b0, 1'b0, 1'b0, NO_RES},
    '{"-",    1'b0, 1'b0, 1'b0, NO_RES},
    '{"-",    1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_TAB, 1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_CR,  1'b0, 1'b0, 1'b0, NO_RES},
    '{"x",    1'b0, 1'b1, 1'b0, NO_RES},
    '{"/",    1'b0, 1'b0, 1'b0, NO_RES},
    '{"*",    1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_LF,  1'b0, 1'b0, 1'b0, NO_RES},
    '{"*",    1'b0, 1'b0, 1'b0, NO_RES},
    '{"q",    1'b0, 1'b1, 1'b1, '{KIND_UNTERM, 8'h00, 16'd1, 1'b1}},
    '{"/",    1'b0, 1'b0, 1'b0, NO_RES},
    '{"-",    1'b0, 1'b1, 1'b0, NO_RES},
    '{"a",    1'b0, 1'b0, 1'b0, NO_RES},
    '{"/",    1'b0, 1'b0, 1'b0, NO_RES},
    '{";",    1'b1, 1'b1, 1'b0, NO_RES}
  };

  sql_style_token_splitter_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic bit one_char_tok(input logic [7:0] c);
    case (c)
      "{", "}", "=", ":", ",", "<", ">", "\"", ".", "(", ")", "[", "]", "'",
      CH_SEMI: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic emit(input logic [1:0] k, input logic [7:0] b);
    if (run_q.size() < MAX_RESULTS)
      run_q.insert(run_q.size(), out_item_t'{kind: k, token_byte: b, line_number: lines,
                                             last_of_run: 1'b0});
  endtask

  task automatic bump_lines();
    if (lines != 16'hFFFF) lines = lines + 16'd1;
  endtask

  task automatic end_token();
    if (tok_open) begin
      emit(KIND_END, 8'h00);
      tok_open = 1'b0;
    end
  endtask

  task automatic let_go_held();
    emit(KIND_CHAR, hold_byte);
    if (hold_is_delim) emit(KIND_END, 8'h00);
    else tok_open = 1'b1;
    hold_on = 1'b0;
    hold_is_delim = 1'b0;
  endtask

  task automatic clear_text();
    tok_open = 1'b0;
    hold_byte = 8'h00;
    hold_on = 1'b0;
    hold_is_delim = 1'b0;
    mode = MODE_TEXT;
    prev_star = 1'b0;
    lines = 16'd0;
  endtask

  // Work out the results of one accepted byte into run_q
  task automatic split_byte(input in_item_t it);
    logic [7:0] c;
    logic       extra;
    c = it.text_byte;
    run_q.delete();
    if (mode == MODE_BLOCK) begin
      if (c == CH_LF) bump_lines();
      if (c == CH_SLASH && prev_star) begin
        mode = MODE_TEXT;
        prev_star = 1'b0;
      end else begin
        prev_star = (c == CH_STAR);
      end
    end else if (mode == MODE_LINE) begin
      if (c == CH_LF || c == CH_CR) begin
        bump_lines();
        mode = MODE_TEXT;
      end
    end else if (hold_on && hold_byte == CH_SLASH && c == CH_STAR) begin
      end_token();
      hold_on = 1'b0;
      hold_is_delim = 1'b0;
      mode = MODE_BLOCK;
      prev_star = 1'b1;   // opener's star may close the comment
    end else if (hold_on && hold_byte == CH_DASH && c == CH_DASH) begin
      end_token();
      hold_on = 1'b0;
      hold_is_delim = 1'b0;
      mode = MODE_LINE;
    end else begin
      if (hold_on) let_go_held();
      extra = it.extra_delim_on && (c == delim_char);
      if (c == CH_SLASH || c == CH_DASH) begin
        // held back; its delimiter class is fixed now
        hold_byte = c;
        hold_on = 1'b1;
        hold_is_delim = extra;
        if (extra) end_token();
      end else if (c == CH_LF || c == CH_CR) begin
        end_token();
        if (c == CH_LF) bump_lines();
      end else if (c == CH_SPACE || c == CH_TAB) begin
        end_token();
      end else if (one_char_tok(c) || extra) begin
        end_token();
        emit(KIND_CHAR, c);
        emit(KIND_END, 8'h00);
      end else begin
        emit(KIND_CHAR, c);
        tok_open = 1'b1;
      end
    end

    // End of text: flush, flag an open block comment, start over
    if (it.end_of_text) begin
      if (hold_on) let_go_held();
      end_token();
      if (mode == MODE_BLOCK) emit(KIND_UNTERM, 8'h00);
      clear_text();
    end

    if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag(input string what);
    err_cnt++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic check_token(input out_item_t got);
    out_item_t want;
    if (token_q.size() == 0) begin
      flag($sformatf("unexpected result kind=%0d byte=%02h line=%0d last=%0d",
                     got.kind, got.token_byte, got.line_number, got.last_of_run));
    end else begin
      want = token_q.pop_front();
      if (got.kind != want.kind)
        flag($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.token_byte != want.token_byte)
        flag($sformatf("token_byte %02h, want %02h", got.token_byte, want.token_byte));
      if (got.line_number != want.line_number)
        flag($sformatf("line_number %0d, want %0d", got.line_number, want.line_number));
      if (got.last_of_run != want.last_of_run)
        flag($sformatf("last_of_run %0d, want %0d", got.last_of_run, want.last_of_run));
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic send(input logic [7:0] c, input logic on, input logic eot,
                      input logic typed, input out_item_t want);
    in_item_t it;
    int       gap;
    it = in_item_t'{text_byte: c, extra_delim_on: on, end_of_text: eot};
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    split_byte(it);
    if (typed) token_q.insert(token_q.size(), want);
    else foreach (run_q[i]) token_q.insert(token_q.size(), run_q[i]);
    bytes_sent++;
    if (jitter && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 11);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_rand(input logic [7:0] c);
    send(c, 1'(($urandom_range(0, 1))), ($urandom_range(0, 39) == 0), 1'b0, NO_RES);
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(8'h30, 8'h39));
      1:       return 8'($urandom_range(8'h80, 8'hFF));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // One random phrase: mostly well-formed words, comments and punctuation
  task automatic send_phrase();
    string punct;
    int    n;
    punct = "{}=:,<>\".()[]';";
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = $urandom_range(1, 6);
        repeat (n) send_rand(pick_letter());
      end
      3: begin
        case ($urandom_range(0, 3))
          0: send_rand(CH_SPACE);
          1: send_rand(CH_TAB);
          2: send_rand(CH_LF);
          default: send_rand(CH_CR);
        endcase
      end
      4: send_rand(punct[$urandom_range(0, punct.len()-1)]);
      5: begin
        // block comment, sometimes left unclosed
        send_rand(CH_SLASH);
        send_rand(CH_STAR);
        n = $urandom_range(0, 5);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: send_rand(CH_STAR);
            1: send_rand(CH_LF);
            2: send_rand(CH_SLASH);
            3: send_rand(CH_SPACE);
            default: send_rand(pick_letter());
          endcase
        end
        if ($urandom_range(0, 3) != 0) begin
          send_rand(CH_STAR);
          send_rand(CH_SLASH);
        end
      end
      6: begin
        // line comment, sometimes with no line break
        send_rand(CH_DASH);
        send_rand(CH_DASH);
        n = $urandom_range(0, 5);
        repeat (n) send_rand(pick_letter());
        case ($urandom_range(0, 3))
          0: send_rand(CH_CR);
          1: ;
          default: send_rand(CH_LF);
        endcase
      end
      7: send_rand(delim_char);
      8: begin
        case ($urandom_range(0, 2))
          0: send_rand(CH_SLASH);
          1: send_rand(CH_DASH);
          default: send_rand(CH_STAR);
        endcase
      end
      default: send_rand(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic run_phase(input int n);
    int stop;
    stop = bytes_sent + n;
    while (bytes_sent < stop) send_phrase();
  endtask

  // Stop sending and wait out every pending result plus the pipeline
  task automatic settle();
    push <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_delim(input logic [7:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    delim_char = v;
  endtask

  // ---------------------------------------------------------------- main flow

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 8'h00;
    push = 1'b0;
    in_data = '0;
    delim_char = EXTRA_DELIM_RESET;
    clear_text();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Fixed script under the reset delimiter
    foreach (script[i])
      send(script[i].c, script[i].on, script[i].eot, script[i].typed, script[i].want);

    // Random text under several delimiter settings
    set_delim(8'h00);
    run_phase(60);
    set_delim(8'hFF);
    run_phase(60);
    set_delim(CH_SLASH);
    run_phase(60);
    set_delim(CH_DASH);
    run_phase(60);
    set_delim(CH_SEMI);
    run_phase(50);
    set_delim(8'($urandom_range(0, 255)));
    run_phase(50);

    // Short line-count stretch and a comment across lines, no idling from here on
    jitter = 1'b0;
    set_delim(EXTRA_DELIM_RESET);
    send("x", 1'b0, 1'b1, 1'b0, NO_RES);
    repeat (5) send(CH_LF, 1'b0, 1'b0, 1'b0, NO_RES);
    send("k", 1'b0, 1'b0, 1'b0, NO_RES);
    send(CH_LF, 1'b0, 1'b0, 1'b0, NO_RES);
    send("/", 1'b0, 1'b0, 1'b0, NO_RES);
    send("*", 1'b0, 1'b0, 1'b0, NO_RES);
    send(CH_LF, 1'b0, 1'b0, 1'b0, NO_RES);
    send("k", 1'b0, 1'b1, 1'b0, NO_RES);

    run_phase(60);
    settle();
    repeat (8) @(posedge clk);

    $display("Sent %0d text bytes (%0d from the fixed script), checked %0d results.",
             bytes_sent, SCRIPT_LEN, tokens_seen);
    $display("Seven delimiter settings, comments, end-of-text flushes, idle-free tail.");
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: random pop stalls, check every accepted result
  initial begin : drain_side
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        check_token(out_data);
        tokens_seen++;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (jitter && $urandom_range(0, 15) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_cnt, token_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
